[rtl/core/point_line_distance_projection_defines.svh]
// assertion macros for the point to line distance block
`ifndef POINT_LINE_DISTANCE_PROJECTION_DEFINES_SVH
`define POINT_LINE_DISTANCE_PROJECTION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PLDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay in cycles
`define PLDP_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

[rtl/core/pldp_pkg.sv]
// shared types and constants for the point to line distance block
package pldp_pkg;

  localparam int NumCells = 32;
  localparam int NumLanes = 4;
  localparam int FrontStages = 6;
  localparam int Latency = FrontStages + NumCells + 1;

  localparam int LaneDist = 0;
  localparam int LaneProjX = 1;
  localparam int LaneProjY = 2;
  localparam int LaneProjZ = 3;

  localparam logic [2:0] RegBaseX = 3'd0;
  localparam logic [2:0] RegBaseY = 3'd1;
  localparam logic [2:0] RegBaseZ = 3'd2;
  localparam logic [2:0] RegDirX = 3'd3;
  localparam logic [2:0] RegDirY = 3'd4;
  localparam logic [2:0] RegDirZ = 3'd5;
  localparam logic [2:0] RegThreshold = 3'd6;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    logic [15:0] index;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic [31:0] thr2;
    logic [31:0] dd;
    logic sat;
    logic degen;
    logic [2:0] neg;
  } side_t;

  typedef struct packed {
    side_t side;
    lane_t [NumLanes-1:0] lane;
  } stage_t;

endpackage

[rtl/core/point_line_distance_projection.sv]
// top level: squared distance of a point to a configured 3d line and its projection
//
// usage: program the line with wr_en/wr_index/wr_data (0..2 base, 3..5 direction,
// 6 threshold) while no request is in flight; writes to index 7 are dropped.
// a request is taken at every clock edge with start high and busy low; busy
// never rises, so one point per cycle streams in.
// each result shows on the output ports for one cycle with done high, after
// its request passes six multiply and sum stages, a row of 32
// division cells that retire one quotient bit per cycle for the distance and
// the three projection lanes, and one result register.
// the receiver cannot stall; results leave in request order, one per cycle.
// reset clears the pipeline valids and loads the default line: base at the
// origin, direction along x, threshold 26; requests in flight are dropped.
`include "point_line_distance_projection_defines.svh"

module point_line_distance_projection (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pt_x,
  input  logic signed [15:0] pt_y,
  input  logic signed [15:0] pt_z,
  input  logic [15:0]        pt_index,
  output logic               done,
  output logic [15:0]        out_index,
  output logic [31:0]        sqr_dist,
  output logic               is_inlier,
  output logic               is_outside,
  output logic signed [15:0] proj_x,
  output logic signed [15:0] proj_y,
  output logic signed [15:0] proj_z,
  output logic               degenerate
);

  logic accept;
  pldp_pkg::stage_t [pldp_pkg::NumCells:0] chain;
  logic [pldp_pkg::NumCells:0] vchain;

  assign busy = 1'b0;
  assign accept = start && !busy;

  pldp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .start     (accept),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .pt_z      (pt_z),
    .pt_index  (pt_index),
    .out_valid (vchain[0]),
    .out_stage (chain[0])
  );

  for (genvar i = 0; i < pldp_pkg::NumCells; i++) begin : g_cell
    pldp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vchain[i]),
      .in_stage  (chain[i]),
      .out_valid (vchain[i+1]),
      .out_stage (chain[i+1])
    );
  end

  pldp_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vchain[pldp_pkg::NumCells]),
    .in_stage   (chain[pldp_pkg::NumCells]),
    .done       (done),
    .out_index  (out_index),
    .sqr_dist   (sqr_dist),
    .is_inlier  (is_inlier),
    .is_outside (is_outside),
    .proj_x     (proj_x),
    .proj_y     (proj_y),
    .proj_z     (proj_z),
    .degenerate (degenerate)
  );

  `PLDP_ASSERT_DLY(a_latency, accept, pldp_pkg::Latency, done, "result missing after request")
  `PLDP_ASSERT_IMP(a_flags_excl, done, !(is_inlier && is_outside), "inlier and outside both set")
  `PLDP_ASSERT_IMP(a_degen_zero, done && degenerate,
                   !is_inlier && !is_outside && (sqr_dist == 32'd0),
                   "degenerate line with nonzero distance or flags")

endmodule

[rtl/core/pldp_front.sv]
// config registers and multiply front end: cross product, dot product, squares
module pldp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [2:0]             wr_index,
  input  logic [15:0]            wr_data,
  input  logic                   start,
  input  logic signed [15:0]     pt_x,
  input  logic signed [15:0]     pt_y,
  input  logic signed [15:0]     pt_z,
  input  logic [15:0]            pt_index,
  output logic                   out_valid,
  output pldp_pkg::stage_t       out_stage
);

  logic signed [15:0] base_x, base_y, base_z, dir_x, dir_y, dir_z;
  logic [15:0] dist_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= '0;
      base_y <= '0;
      base_z <= '0;
      dir_x <= 16'sd256;
      dir_y <= '0;
      dir_z <= '0;
      dist_threshold <= 16'd26;
    end else if (wr_en) begin
      case (wr_index)
        pldp_pkg::RegBaseX: base_x <= wr_data;
        pldp_pkg::RegBaseY: base_y <= wr_data;
        pldp_pkg::RegBaseZ: base_z <= wr_data;
        pldp_pkg::RegDirX: dir_x <= wr_data;
        pldp_pkg::RegDirY: dir_y <= wr_data;
        pldp_pkg::RegDirZ: dir_z <= wr_data;
        pldp_pkg::RegThreshold: dist_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // side data carried through the front stages
  logic [15:0] idx1, idx2, idx3, idx4, idx5;
  logic signed [15:0] bx1, by1, bz1, bx2, by2, bz2, bx3, by3, bz3;
  logic signed [15:0] bx4, by4, bz4, bx5, by5, bz5;
  logic signed [15:0] dx1, dy1, dz1, dx2, dy2, dz2, dx3, dy3, dz3;
  logic [31:0] thr2_1, thr2_2, thr2_3, thr2_4, thr2_5;
  logic [31:0] dd2, dd3, dd4, dd5;
  logic degen3, degen4, degen5;
  logic [5:0] vld;

  // stage 1
  logic signed [17:0] ppx, ppy, ppz;
  logic signed [16:0] pbx, pby, pbz;
  logic [30:0] dsqx, dsqy, dsqz;
  logic signed [31:0] dsqx_w, dsqy_w, dsqz_w;
  // stage 2
  logic signed [33:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  logic signed [32:0] tpx, tpy, tpz;
  // stage 3
  logic signed [34:0] cx, cy, cz, tdot;
  // stage 4
  logic signed [69:0] sqx_w, sqy_w, sqz_w;
  logic [67:0] sqx, sqy, sqz;
  logic signed [50:0] nx, ny, nz;
  // stage 5
  logic [69:0] nsum;
  logic [50:0] magx, magy, magz;
  logic [2:0] neg5;

  assign dsqx_w = dir_x * dir_x;
  assign dsqy_w = dir_y * dir_y;
  assign dsqz_w = dir_z * dir_z;
  assign sqx_w = cx * cx;
  assign sqy_w = cy * cy;
  assign sqz_w = cz * cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: differences and squared direction
    ppx <= 18'(base_x) + 18'(dir_x) - 18'(pt_x);
    ppy <= 18'(base_y) + 18'(dir_y) - 18'(pt_y);
    ppz <= 18'(base_z) + 18'(dir_z) - 18'(pt_z);
    pbx <= 17'(pt_x) - 17'(base_x);
    pby <= 17'(pt_y) - 17'(base_y);
    pbz <= 17'(pt_z) - 17'(base_z);
    dsqx <= dsqx_w[30:0];
    dsqy <= dsqy_w[30:0];
    dsqz <= dsqz_w[30:0];
    thr2_1 <= 32'(dist_threshold) * 32'(dist_threshold);
    idx1 <= pt_index;
    bx1 <= base_x; by1 <= base_y; bz1 <= base_z;
    dx1 <= dir_x; dy1 <= dir_y; dz1 <= dir_z;

    // stage 2: cross and dot partial products
    m_yz <= ppy * dz1;
    m_zy <= ppz * dy1;
    m_zx <= ppz * dx1;
    m_xz <= ppx * dz1;
    m_xy <= ppx * dy1;
    m_yx <= ppy * dx1;
    tpx <= pbx * dx1;
    tpy <= pby * dy1;
    tpz <= pbz * dz1;
    dd2 <= 32'(dsqx) + 32'(dsqy) + 32'(dsqz);
    idx2 <= idx1; thr2_2 <= thr2_1;
    bx2 <= bx1; by2 <= by1; bz2 <= bz1;
    dx2 <= dx1; dy2 <= dy1; dz2 <= dz1;

    // stage 3: cross product and dot product
    cx <= 35'(m_yz) - 35'(m_zy);
    cy <= 35'(m_zx) - 35'(m_xz);
    cz <= 35'(m_xy) - 35'(m_yx);
    tdot <= 35'(tpx) + 35'(tpy) + 35'(tpz);
    degen3 <= (dd2 == 32'd0);
    dd3 <= dd2; idx3 <= idx2; thr2_3 <= thr2_2;
    bx3 <= bx2; by3 <= by2; bz3 <= bz2;
    dx3 <= dx2; dy3 <= dy2; dz3 <= dz2;

    // stage 4: squares of the cross product, projection numerators
    sqx <= sqx_w[67:0];
    sqy <= sqy_w[67:0];
    sqz <= sqz_w[67:0];
    nx <= tdot * dx3;
    ny <= tdot * dy3;
    nz <= tdot * dz3;
    degen4 <= degen3; dd4 <= dd3; idx4 <= idx3; thr2_4 <= thr2_3;
    bx4 <= bx3; by4 <= by3; bz4 <= bz3;

    // stage 5: squared norm sum, numerator magnitudes
    nsum <= 70'(sqx) + 70'(sqy) + 70'(sqz);
    neg5 <= {nz[50], ny[50], nx[50]};
    magx <= nx[50] ? 51'(-nx) : 51'(nx);
    magy <= ny[50] ? 51'(-ny) : 51'(ny);
    magz <= nz[50] ? 51'(-nz) : 51'(nz);
    degen5 <= degen4; dd5 <= dd4; idx5 <= idx4; thr2_5 <= thr2_4;
    bx5 <= bx4; by5 <= by4; bz5 <= bz4;
  end

  // stage 6: saturation check and divider lane setup
  logic sat6;
  logic [63:0] dnum;
  assign sat6 = nsum >= {6'd0, dd5, 32'd0};
  assign dnum = sat6 ? 64'd0 : nsum[63:0];

  always_ff @(posedge clk) begin
    out_stage.side.index <= idx5;
    out_stage.side.base_x <= bx5;
    out_stage.side.base_y <= by5;
    out_stage.side.base_z <= bz5;
    out_stage.side.thr2 <= thr2_5;
    out_stage.side.dd <= dd5;
    out_stage.side.sat <= sat6;
    out_stage.side.degen <= degen5;
    out_stage.side.neg <= neg5;
    out_stage.lane[pldp_pkg::LaneDist].rem <= dnum[63:32];
    out_stage.lane[pldp_pkg::LaneDist].quo <= dnum[31:0];
    // projection quotients stay far below 2^32, so the high word (magnitude bits 50:32) starts below dd
    out_stage.lane[pldp_pkg::LaneProjX].rem <= 32'(magx[50:32]);
    out_stage.lane[pldp_pkg::LaneProjX].quo <= magx[31:0];
    out_stage.lane[pldp_pkg::LaneProjY].rem <= 32'(magy[50:32]);
    out_stage.lane[pldp_pkg::LaneProjY].quo <= magy[31:0];
    out_stage.lane[pldp_pkg::LaneProjZ].rem <= 32'(magz[50:32]);
    out_stage.lane[pldp_pkg::LaneProjZ].quo <= magz[31:0];
  end

  assign out_valid = vld[5];

endmodule

[rtl/core/pldp_div_cell.sv]
// one restoring division step for every lane, registered toward the next cell
module pldp_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pldp_pkg::stage_t  in_stage,
  output logic              out_valid,
  output pldp_pkg::stage_t  out_stage
);

  logic [32:0] r2 [pldp_pkg::NumLanes];
  logic [32:0] diff [pldp_pkg::NumLanes];
  logic [pldp_pkg::NumLanes-1:0] ge;
  pldp_pkg::stage_t stage_next;

  always_comb begin
    stage_next.side = in_stage.side;
    for (int l = 0; l < pldp_pkg::NumLanes; l++) begin
      // shift in the next numerator bit, subtract when the divisor fits
      r2[l] = {in_stage.lane[l].rem, in_stage.lane[l].quo[31]};
      diff[l] = r2[l] - {1'b0, in_stage.side.dd};
      ge[l] = r2[l] >= {1'b0, in_stage.side.dd};
      stage_next.lane[l].rem = ge[l] ? diff[l][31:0] : r2[l][31:0];
      stage_next.lane[l].quo = {in_stage.lane[l].quo[30:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

[rtl/core/pldp_finish.sv]
// threshold flags, floor correction, projection saturation and result register
module pldp_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  pldp_pkg::stage_t   in_stage,
  output logic               done,
  output logic [15:0]        out_index,
  output logic [31:0]        sqr_dist,
  output logic               is_inlier,
  output logic               is_outside,
  output logic signed [15:0] proj_x,
  output logic signed [15:0] proj_y,
  output logic signed [15:0] proj_z,
  output logic               degenerate
);

  function automatic logic [15:0] proj_comp(input logic signed [15:0] base,
                                            input pldp_pkg::lane_t ln,
                                            input logic neg);
    logic [19:0] qm;
    logic signed [19:0] qs;
    logic signed [20:0] sum;
    qm = {1'b0, ln.quo[18:0]};
    // floor toward minus infinity for a negative numerator
    qs = neg ? -(qm + 20'(ln.rem != 32'd0)) : qm;
    sum = 21'(base) + 21'(qs);
    if (sum > 21'sd32767) begin
      return 16'h7fff;
    end else if (sum < -21'sd32768) begin
      return 16'h8000;
    end
    return sum[15:0];
  endfunction

  logic [31:0] q, r, thr2;
  logic sat, degen;
  assign q = in_stage.lane[pldp_pkg::LaneDist].quo;
  assign r = in_stage.lane[pldp_pkg::LaneDist].rem;
  assign thr2 = in_stage.side.thr2;
  assign sat = in_stage.side.sat;
  assign degen = in_stage.side.degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_index <= in_stage.side.index;
    degenerate <= degen;
    if (degen) begin
      sqr_dist <= '0;
      is_inlier <= 1'b0;
      is_outside <= 1'b0;
      proj_x <= in_stage.side.base_x;
      proj_y <= in_stage.side.base_y;
      proj_z <= in_stage.side.base_z;
    end else begin
      sqr_dist <= sat ? 32'hffff_ffff : q;
      // with remainder below dd the quotient decides against thr2; on a tie a nonzero remainder means outside
      is_inlier <= !sat && (q < thr2);
      is_outside <= sat || (q > thr2) || ((q == thr2) && (r != 32'd0));
      proj_x <= proj_comp(in_stage.side.base_x, in_stage.lane[pldp_pkg::LaneProjX],
                          in_stage.side.neg[0]);
      proj_y <= proj_comp(in_stage.side.base_y, in_stage.lane[pldp_pkg::LaneProjY],
                          in_stage.side.neg[1]);
      proj_z <= proj_comp(in_stage.side.base_z, in_stage.lane[pldp_pkg::LaneProjZ],
                          in_stage.side.neg[2]);
    end
  end

endmodule

[tb/sv/point_line_distance_projection_tb.sv]
// self-checking testbench for point_line_distance_projection with a scoreboard class
module point_line_distance_projection_tb;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [15:0] index;
    logic [31:0] sqd;
    logic inlier;
    logic outside;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic degen;
  } line_result_t;

  class projection_scoreboard;
    logic signed [15:0] base[3];
    logic signed [15:0] dirv[3];
    logic [15:0] thr;
    line_result_t pending_results[$];
    int errors;

    function new();
      base = '{16'sd0, 16'sd0, 16'sd0};
      dirv = '{16'sd256, 16'sd0, 16'sd0};
      thr = 16'd26;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      if (idx <= pldp_pkg::RegBaseZ) base[idx] = v;
      else if (idx <= pldp_pkg::RegDirZ) dirv[idx - pldp_pkg::RegDirX] = v;
      else if (idx == pldp_pkg::RegThreshold) thr = v;
    endfunction

    function line_result_t fit_point(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] z, logic [15:0] idx);
      line_result_t r;
      longint b[3], d[3], p[3], pp[3], c[3], pr[3];
      longint dd, t, num, q;
      logic [127:0] n, m, lim, tlim;
      p[0] = x; p[1] = y; p[2] = z;
      for (int i = 0; i < 3; i++) begin
        b[i] = base[i];
        d[i] = dirv[i];
        pp[i] = b[i] + d[i] - p[i];
      end
      dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      r.index = idx;
      r.inlier = 0;
      r.outside = 0;
      r.degen = 0;
      if (dd == 0) begin
        r.degen = 1;
        r.sqd = 0;
        for (int i = 0; i < 3; i++) pr[i] = b[i];
      end else begin
        c[0] = pp[1] * d[2] - pp[2] * d[1];
        c[1] = pp[2] * d[0] - pp[0] * d[2];
        c[2] = pp[0] * d[1] - pp[1] * d[0];
        n = 0;
        for (int i = 0; i < 3; i++) begin
          m = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
          n = n + m * m;
        end
        lim = 128'(dd) << 32;
        r.sqd = (n >= lim) ? 32'hFFFF_FFFF : 32'(n / 128'(dd));
        tlim = 128'(thr) * 128'(thr) * 128'(dd);
        r.inlier = n < tlim;
        r.outside = n > tlim;
        t = (p[0] - b[0]) * d[0] + (p[1] - b[1]) * d[1] + (p[2] - b[2]) * d[2];
        for (int i = 0; i < 3; i++) begin
          num = t * d[i];
          // round toward minus infinity
          q = (num >= 0) ? num / dd : -((-num + dd - 1) / dd);
          pr[i] = b[i] + q;
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (pr[i] > 32767) pr[i] = 32767;
        if (pr[i] < -32768) pr[i] = -32768;
      end
      r.px = 16'(pr[0]);
      r.py = 16'(pr[1]);
      r.pz = 16'(pr[2]);
      return r;
    endfunction

    function void note_request(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, logic [15:0] idx);
      pending_results.push_back(fit_point(x, y, z, idx));
    endfunction

    function void check_result(line_result_t got);
      line_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with index %0d arrived with nothing pending", got.index);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.index !== e.index) begin
        $error("out_index: expected %0d, got %0d", e.index, got.index); errors++;
      end
      if (got.sqd !== e.sqd) begin
        $error("sqr_dist: expected %0h, got %0h", e.sqd, got.sqd); errors++;
      end
      if (got.inlier !== e.inlier) begin
        $error("is_inlier: expected %0b, got %0b", e.inlier, got.inlier); errors++;
      end
      if (got.outside !== e.outside) begin
        $error("is_outside: expected %0b, got %0b", e.outside, got.outside); errors++;
      end
      if (got.px !== e.px) begin
        $error("proj_x: expected %0d, got %0d", e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $error("proj_y: expected %0d, got %0d", e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
        $error("proj_z: expected %0d, got %0d", e.pz, got.pz); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate: expected %0b, got %0b", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [15:0] wr_data = '0;
  logic start = 0;
  logic busy;
  logic signed [15:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic [15:0] pt_index = '0;
  logic done;
  logic [15:0] out_index;
  logic [31:0] sqr_dist;
  logic is_inlier, is_outside, degenerate;
  logic signed [15:0] proj_x, proj_y, proj_z;

  projection_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  logic [15:0] next_index = 0;

  point_line_distance_projection uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    line_result_t got;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("point_line_distance_projection_tb failed");
      $finish;
    end
    if (!rst && done) begin
      got.index = out_index; got.sqd = sqr_dist;
      got.inlier = is_inlier; got.outside = is_outside;
      got.px = proj_x; got.py = proj_y; got.pz = proj_z;
      got.degen = degenerate;
      sb.check_result(got);
    end
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic [15:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    pt_x <= x; pt_y <= y; pt_z <= z; pt_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(x, y, z, idx);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    start <= 0;
    wr_en <= 1; wr_index <= idx; wr_data <= v;
    @(posedge clk);
    wr_en <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_line(int mode);
    for (int i = 0; i < 3; i++) begin
      write_reg(3'(pldp_pkg::RegBaseX + i),
                (mode == 0) ? pick_extreme() : 16'($urandom_range(0, 8191) - 4096));
      case (mode)
        0: write_reg(3'(pldp_pkg::RegDirX + i), pick_extreme());
        1: write_reg(3'(pldp_pkg::RegDirX + i), 16'($urandom_range(0, 1024) - 512));
        2: write_reg(3'(pldp_pkg::RegDirX + i), 16'h0000);
        default: write_reg(3'(pldp_pkg::RegDirX + i), 16'($urandom));
      endcase
    end
    case ($urandom_range(4))
      0: write_reg(pldp_pkg::RegThreshold, 16'h0000);
      1: write_reg(pldp_pkg::RegThreshold, 16'hFFFF);
      2: write_reg(pldp_pkg::RegThreshold, 16'($urandom));
      default: write_reg(pldp_pkg::RegThreshold, 16'($urandom_range(1, 2048)));
    endcase
    @(posedge clk);
  endtask

  task automatic random_points(int count);
    int span, mul;
    logic [15:0] c[3];
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 3) begin
        for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
      end else begin
        // points around the line so both flags show up
        span = sb.thr / 2 + 8;
        mul = int'($urandom_range(0, 1024)) - 512;
        for (int i = 0; i < 3; i++)
          c[i] = 16'(int'(sb.base[i]) + ((mul * int'(sb.dirv[i])) >>> 8) +
                     int'($urandom_range(0, 2 * span)) - span);
      end
      send_point(c[0], c[1], c[2], next_index);
      next_index = 16'($urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default line along x: exact-threshold point, far points, field extremes
    send_point(16'sd0, 16'sd26, 16'sd0, 16'h0000);
    send_point(16'sd100, 16'sd0, 16'sd25, 16'hFFFF);
    send_point(16'sd0, 16'sd27, 16'sd0, 16'h1234);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h0001);
    drain();
    // dropped write then an extreme line, including a point whose distance saturates
    write_reg(RegUnused, 16'h5555);
    write_reg(pldp_pkg::RegBaseX, 16'h7FFF); write_reg(pldp_pkg::RegBaseY, 16'h8000);
    write_reg(pldp_pkg::RegBaseZ, 16'h7FFF); write_reg(pldp_pkg::RegDirX, 16'h8000);
    write_reg(pldp_pkg::RegDirY, 16'h8000); write_reg(pldp_pkg::RegDirZ, 16'h7FFF);
    write_reg(pldp_pkg::RegThreshold, 16'hFFFF);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 16'd2);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'd3);
    send_point(16'sd0, 16'sd0, 16'sd0, 16'd4);
    drain();
    // zero direction
    write_reg(pldp_pkg::RegDirX, 16'h0000); write_reg(pldp_pkg::RegDirY, 16'h0000);
    write_reg(pldp_pkg::RegDirZ, 16'h0000); write_reg(pldp_pkg::RegThreshold, 16'h0000);
    send_point(16'sd5, 16'sd6, 16'sd7, 16'd5);
    send_point(16'h8000, 16'h7FFF, 16'h0000, 16'd6);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 88 : 0;
      for (int s = 0; s < 4; s++) begin
        load_line((ph + s) % 4);
        random_points(153);
        drain();
      end
    end

    repeat (pldp_pkg::Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("point_line_distance_projection_tb passed");
    end else begin
      $display("point_line_distance_projection_tb failed");
    end
    $finish;
  end
endmodule
